// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the point transform RTL.
// Bodies are empty when SYNTHESIS is defined; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(cond), msg)
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/ptx_pkg.sv =====
// Shared types and constants of the 2-D point transform block.
// Depends on nothing; every RTL module imports it.
package ptx_pkg;

    localparam int MODE_BITS      = 2;
    localparam int ANGLE_BITS     = 14;
    localparam int FACTOR_BITS    = 16;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ROTATE    = 2'd0,
        MODE_TRANSLATE = 2'd1,
        MODE_SCALE     = 2'd2,
        MODE_PASS      = 2'd3
    } ptx_mode_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIVOT_X  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIVOT_Y  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_X = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_Y = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR_X = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR_Y = 3'd7;

    typedef struct packed {
        logic      valid;
        ptx_mode_t mode;
        logic      x_above;
        logic      x_below;
        logic      y_above;
        logic      y_below;
    } ptx_stage_ctrl_t;

    typedef enum logic [1:0] {
        TRIG_IDLE  = 2'd0,
        TRIG_ITER  = 2'd1,
        TRIG_ROUND = 2'd2
    } ptx_trig_state_t;

    // Angles are Q9.4 degrees: a full turn is 360 * 16.
    localparam int ANG_FULL    = 5760;
    localparam int ANG_HALF    = 2880;
    localparam int ANG_QUARTER = 1440;
    localparam int ANGLE_SHIFT = 12;

    localparam int CORDIC_STAGES = 18;
    localparam int CORDIC_FRAC   = 30;
    localparam int ITER_BITS     = 5;
    localparam int XY_BITS       = 33;
    localparam int Z_BITS        = 28;
    localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = 33'sd652032874;

    // Arctangent of 2^-i in degrees, scaled by 2^16.
    function automatic logic signed [Z_BITS-1:0] atan_q16(input logic [ITER_BITS-1:0] idx);
        logic signed [Z_BITS-1:0] r;
        case (idx)
            5'd0:    r = Z_BITS'(2949120);
            5'd1:    r = Z_BITS'(1740968);
            5'd2:    r = Z_BITS'(919880);
            5'd3:    r = Z_BITS'(466945);
            5'd4:    r = Z_BITS'(234378);
            5'd5:    r = Z_BITS'(117303);
            5'd6:    r = Z_BITS'(58666);
            5'd7:    r = Z_BITS'(29335);
            5'd8:    r = Z_BITS'(14668);
            5'd9:    r = Z_BITS'(7334);
            5'd10:   r = Z_BITS'(3667);
            5'd11:   r = Z_BITS'(1833);
            5'd12:   r = Z_BITS'(917);
            5'd13:   r = Z_BITS'(458);
            5'd14:   r = Z_BITS'(229);
            5'd15:   r = Z_BITS'(115);
            5'd16:   r = Z_BITS'(57);
            5'd17:   r = Z_BITS'(29);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/point_transform_2d_core.sv =====
// Top level of the 2-D point transform: configuration registers, the sine and
// cosine unit, and the point pipeline. Uses ptx_pkg, ptx_trig,
// ptx_mul_stage, ptx_out_stage and assert_macros.svh.
// Points enter on the s_ channel (valid/ready) and leave on the m_ channel with
// the transformed coordinates and a clipped flag; one result per point, in order.
// Throughput is one point per cycle while the receiver keeps up and no angle is
// being formed; a result passes through the input, product and result registers.
// A stalled receiver fills the result register, then the product and input
// registers, and makes s_ready fall only when all three hold items.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata. The user
// must write it only while no point is in flight; the block has no check for it.
// Writing the angle starts the iterative CORDIC, 18 steps plus a rounding step, so
// s_ready is low in the write cycle and while the steps and rounding run.
// Reset clears the pipeline, loads the register reset values and sets sine to
// zero and cosine to one; there is no clearing pass.
`include "assert_macros.svh"
module point_transform_2d_core #(
    parameter int COORD_BITS     = 24,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_wr_en,
    input  logic [ptx_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [((COORD_BITS > ptx_pkg::FACTOR_BITS) ? COORD_BITS
                   : ptx_pkg::FACTOR_BITS)-1:0]      cfg_wdata,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [COORD_BITS-1:0]             s_in_x,
    input  logic signed [COORD_BITS-1:0]             s_in_y,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [COORD_BITS-1:0]             m_out_x,
    output logic signed [COORD_BITS-1:0]             m_out_y,
    output logic                                     m_clipped
);
    import ptx_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PW = COORD_BITS + TRIG_FRAC_BITS + 3;
    localparam int SW = COORD_BITS + FACTOR_BITS + 1;

    ptx_mode_t mode_reg;
    logic signed [CB-1:0] pivot_x_reg, pivot_y_reg, offset_x_reg, offset_y_reg;
    logic signed [FACTOR_BITS-1:0] factor_x_reg, factor_y_reg;

    logic angle_start, trig_busy, in_room, in_load, out_room;
    logic signed [TW-1:0] sine, cosine;
    ptx_stage_ctrl_t prod_ctrl;
    logic signed [PW-1:0] rot_xc, rot_ys, rot_xs, rot_yc;
    logic [SW-1:0] scl_x, scl_y;
    logic signed [CB:0] trn_x, trn_y;
    logic signed [CB-1:0] pass_x, pass_y;

    assign angle_start = cfg_wr_en && (cfg_index == REG_ANGLE);
    assign s_ready     = in_room && !trig_busy && !angle_start;
    assign in_load     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_ROTATE;
            pivot_x_reg  <= '0;
            pivot_y_reg  <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            factor_x_reg <= FACTOR_BITS'(256);
            factor_y_reg <= FACTOR_BITS'(256);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= ptx_mode_t'(cfg_wdata[MODE_BITS-1:0]);
                REG_PIVOT_X:  pivot_x_reg  <= cfg_wdata[CB-1:0];
                REG_PIVOT_Y:  pivot_y_reg  <= cfg_wdata[CB-1:0];
                REG_OFFSET_X: offset_x_reg <= cfg_wdata[CB-1:0];
                REG_OFFSET_Y: offset_y_reg <= cfg_wdata[CB-1:0];
                REG_FACTOR_X: factor_x_reg <= cfg_wdata[FACTOR_BITS-1:0];
                REG_FACTOR_Y: factor_y_reg <= cfg_wdata[FACTOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    ptx_trig #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_trig (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (angle_start),
        .angle   (cfg_wdata[ANGLE_BITS-1:0]),
        .sine    (sine),
        .cosine  (cosine),
        .busy    (trig_busy)
    );

    ptx_mul_stage #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_mul_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_load   (in_load),
        .in_x      (s_in_x),
        .in_y      (s_in_y),
        .in_room   (in_room),
        .mode      (mode_reg),
        .pivot_x   (pivot_x_reg),
        .pivot_y   (pivot_y_reg),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .factor_x  (factor_x_reg),
        .factor_y  (factor_y_reg),
        .sine      (sine),
        .cosine    (cosine),
        .out_room  (out_room),
        .prod_ctrl (prod_ctrl),
        .rot_xc    (rot_xc),
        .rot_ys    (rot_ys),
        .rot_xs    (rot_xs),
        .rot_yc    (rot_yc),
        .scl_x     (scl_x),
        .scl_y     (scl_y),
        .trn_x     (trn_x),
        .trn_y     (trn_y),
        .pass_x    (pass_x),
        .pass_y    (pass_y)
    );

    ptx_out_stage #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .prod_ctrl (prod_ctrl),
        .rot_xc    (rot_xc),
        .rot_ys    (rot_ys),
        .rot_xs    (rot_xs),
        .rot_yc    (rot_yc),
        .scl_x     (scl_x),
        .scl_y     (scl_y),
        .trn_x     (trn_x),
        .trn_y     (trn_y),
        .pass_x    (pass_x),
        .pass_y    (pass_y),
        .pivot_x   (pivot_x_reg),
        .pivot_y   (pivot_y_reg),
        .out_room  (out_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_x   (m_out_x),
        .m_out_y   (m_out_y),
        .m_clipped (m_clipped)
    );

    `ASSERT_NEVER(a_no_accept_while_trig_busy, aclk, aresetn, s_ready && trig_busy, "input ready while sine and cosine are being formed")
    `ASSERT_PROP(a_angle_write_starts_trig, aclk, aresetn, angle_start |=> trig_busy, "angle write did not start the CORDIC")
    `ASSERT_PROP(a_clip_at_limit, aclk, aresetn, (m_valid && m_clipped) |-> ((&m_out_x[CB-2:0] && !m_out_x[CB-1]) || (!(|m_out_x[CB-2:0]) && m_out_x[CB-1]) || (&m_out_y[CB-2:0] && !m_out_y[CB-1]) || (!(|m_out_y[CB-2:0]) && m_out_y[CB-1])), "clipped result has no coordinate at a limit")

endmodule

// ===== hw/rtl/ptx_trig.sv =====
// Iterative CORDIC that forms sine and cosine from the rotation angle.
// Uses ptx_pkg for the angle constants, arctangent table and state type.
module ptx_trig #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [ptx_pkg::ANGLE_BITS-1:0]       angle,
    output logic signed [TRIG_FRAC_BITS+1:0]     sine,
    output logic signed [TRIG_FRAC_BITS+1:0]     cosine,
    output logic                                 busy
);
    import ptx_pkg::*;

    localparam int TW    = TRIG_FRAC_BITS + 2;
    localparam int SHIFT = CORDIC_FRAC - TRIG_FRAC_BITS;
    localparam int RW    = XY_BITS + 1;
    localparam logic signed [RW-1:0] ROUND_HALF =
        {{(RW-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};
    localparam logic signed [RW-1:0] ONE_R =
        {{(RW-TRIG_FRAC_BITS-1){1'b0}}, 1'b1, {TRIG_FRAC_BITS{1'b0}}};
    localparam logic signed [TW-1:0] ONE_T = {2'b01, {TRIG_FRAC_BITS{1'b0}}};

    ptx_trig_state_t state_reg, state_next;
    logic [ITER_BITS-1:0] iter_reg;
    logic signed [XY_BITS-1:0] x_reg, y_reg;
    logic signed [Z_BITS-1:0] z_reg;
    logic flip_reg;
    logic signed [TW-1:0] sine_reg, cosine_reg;

    logic do_step, do_round;
    logic signed [ANGLE_BITS:0] ang_wide, ang_mod, ang_half, ang_fold;
    logic fold_flip;
    logic signed [Z_BITS-1:0] z_load, z_step;
    logic signed [XY_BITS-1:0] x_shift, y_shift, x_step, y_step;

    function automatic logic signed [TW-1:0] trig_round(input logic signed [XY_BITS-1:0] v,
                                                        input logic flip);
        logic signed [RW-1:0] w;
        logic signed [TW-1:0] r;
        w = ($signed({v[XY_BITS-1], v}) + ROUND_HALF) >>> SHIFT;
        if (w > ONE_R) begin
            r = ONE_T;
        end else if (w < -ONE_R) begin
            r = -ONE_T;
        end else begin
            r = w[TW-1:0];
        end
        if (flip) begin
            r = -r;
        end
        return r;
    endfunction

    // Reduce the angle to [-180, 180) and fold it into [-90, 90].
    always_comb begin
        ang_wide = {angle[ANGLE_BITS-1], angle};
        if (ang_wide < -ANG_FULL) begin
            ang_mod = (ANGLE_BITS+1)'(ang_wide + 2 * ANG_FULL);
        end else if (ang_wide < 0) begin
            ang_mod = (ANGLE_BITS+1)'(ang_wide + ANG_FULL);
        end else if (ang_wide >= ANG_FULL) begin
            ang_mod = (ANGLE_BITS+1)'(ang_wide - ANG_FULL);
        end else begin
            ang_mod = ang_wide;
        end
        if (ang_mod >= ANG_HALF) begin
            ang_half = (ANGLE_BITS+1)'(ang_mod - ANG_FULL);
        end else begin
            ang_half = ang_mod;
        end
        fold_flip = 1'b0;
        if (ang_half > ANG_QUARTER) begin
            ang_fold  = (ANGLE_BITS+1)'(ang_half - ANG_HALF);
            fold_flip = 1'b1;
        end else if (ang_half < -ANG_QUARTER) begin
            ang_fold  = (ANGLE_BITS+1)'(ang_half + ANG_HALF);
            fold_flip = 1'b1;
        end else begin
            ang_fold = ang_half;
        end
        z_load = {{(Z_BITS-ANGLE_BITS-1-ANGLE_SHIFT){ang_fold[ANGLE_BITS]}}, ang_fold,
                  {ANGLE_SHIFT{1'b0}}};
    end

    always_comb begin
        x_shift = x_reg >>> iter_reg;
        y_shift = y_reg >>> iter_reg;
        if (!z_reg[Z_BITS-1]) begin
            x_step = x_reg - y_shift;
            y_step = y_reg + x_shift;
            z_step = z_reg - atan_q16(iter_reg);
        end else begin
            x_step = x_reg + y_shift;
            y_step = y_reg - x_shift;
            z_step = z_reg + atan_q16(iter_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TRIG_IDLE: begin
                if (start) begin
                    state_next = TRIG_ITER;
                end
            end
            TRIG_ITER: begin
                if (start) begin
                    state_next = TRIG_ITER;
                end else if (iter_reg == ITER_BITS'(CORDIC_STAGES - 1)) begin
                    state_next = TRIG_ROUND;
                end
            end
            TRIG_ROUND: begin
                if (start) begin
                    state_next = TRIG_ITER;
                end else begin
                    state_next = TRIG_IDLE;
                end
            end
            default: state_next = TRIG_IDLE;
        endcase
    end

    always_comb begin
        busy     = 1'b1;
        do_step  = 1'b0;
        do_round = 1'b0;
        case (state_reg)
            TRIG_IDLE:  busy     = 1'b0;
            TRIG_ITER:  do_step  = 1'b1;
            TRIG_ROUND: do_round = 1'b1;
            default:    busy     = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= TRIG_IDLE;
            iter_reg   <= '0;
            sine_reg   <= '0;
            cosine_reg <= ONE_T;
        end else begin
            state_reg <= state_next;
            if (start) begin
                iter_reg <= '0;
            end else if (do_step) begin
                iter_reg <= iter_reg + ITER_BITS'(1);
            end
            if (do_round && !start) begin
                sine_reg   <= trig_round(y_reg, flip_reg);
                cosine_reg <= trig_round(x_reg, flip_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_load;
            flip_reg <= fold_flip;
        end else if (do_step) begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

// ===== hw/rtl/ptx_mul_stage.sv =====
// Input register and product register of the point pipeline.
// Forms differences, rotation and scale products and offsets; uses ptx_pkg.
module ptx_mul_stage #(
    parameter int COORD_BITS     = 24,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_load,
    input  logic signed [COORD_BITS-1:0]                in_x,
    input  logic signed [COORD_BITS-1:0]                in_y,
    output logic                                        in_room,
    input  ptx_pkg::ptx_mode_t                          mode,
    input  logic signed [COORD_BITS-1:0]                pivot_x,
    input  logic signed [COORD_BITS-1:0]                pivot_y,
    input  logic signed [COORD_BITS-1:0]                offset_x,
    input  logic signed [COORD_BITS-1:0]                offset_y,
    input  logic signed [ptx_pkg::FACTOR_BITS-1:0]      factor_x,
    input  logic signed [ptx_pkg::FACTOR_BITS-1:0]      factor_y,
    input  logic signed [TRIG_FRAC_BITS+1:0]            sine,
    input  logic signed [TRIG_FRAC_BITS+1:0]            cosine,
    input  logic                                        out_room,
    output ptx_pkg::ptx_stage_ctrl_t                    prod_ctrl,
    output logic signed [COORD_BITS+TRIG_FRAC_BITS+2:0] rot_xc,
    output logic signed [COORD_BITS+TRIG_FRAC_BITS+2:0] rot_ys,
    output logic signed [COORD_BITS+TRIG_FRAC_BITS+2:0] rot_xs,
    output logic signed [COORD_BITS+TRIG_FRAC_BITS+2:0] rot_yc,
    output logic [COORD_BITS+ptx_pkg::FACTOR_BITS:0]    scl_x,
    output logic [COORD_BITS+ptx_pkg::FACTOR_BITS:0]    scl_y,
    output logic signed [COORD_BITS:0]                  trn_x,
    output logic signed [COORD_BITS:0]                  trn_y,
    output logic signed [COORD_BITS-1:0]                pass_x,
    output logic signed [COORD_BITS-1:0]                pass_y
);
    import ptx_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PW = COORD_BITS + TRIG_FRAC_BITS + 3;
    localparam int AF = FACTOR_BITS + 1;
    localparam int SW = COORD_BITS + FACTOR_BITS + 1;

    logic a_valid_reg;
    logic signed [CB-1:0] a_x_reg, a_y_reg;
    ptx_stage_ctrl_t ctrl_reg, ctrl_next;
    logic b_room;

    logic signed [CB:0] dx, dy, sdx, sdy, sdx_neg, sdy_neg, trn_x_next, trn_y_next;
    logic [CB-1:0] mag_x, mag_y;
    logic signed [AF-1:0] fx_wide, fy_wide, fx_neg, fy_neg;
    logic [AF-1:0] fx_abs, fy_abs;
    logic signed [PW-1:0] rot_xc_next, rot_ys_next, rot_xs_next, rot_yc_next;
    logic [SW-1:0] scl_x_next, scl_y_next;

    logic signed [PW-1:0] rot_xc_reg, rot_ys_reg, rot_xs_reg, rot_yc_reg;
    logic [SW-1:0] scl_x_reg, scl_y_reg;
    logic signed [CB:0] trn_x_reg, trn_y_reg;
    logic signed [CB-1:0] pass_x_reg, pass_y_reg;

    assign b_room  = !ctrl_reg.valid || out_room;
    assign in_room = !a_valid_reg || b_room;

    always_comb begin
        dx  = {a_x_reg[CB-1], a_x_reg} - {pivot_x[CB-1], pivot_x};
        dy  = {a_y_reg[CB-1], a_y_reg} - {pivot_y[CB-1], pivot_y};
        sdx = -dx;
        sdy = -dy;
        sdx_neg = dx;
        sdy_neg = dy;
        mag_x = sdx[CB] ? sdx_neg[CB-1:0] : sdx[CB-1:0];
        mag_y = sdy[CB] ? sdy_neg[CB-1:0] : sdy[CB-1:0];
        fx_wide = {factor_x[FACTOR_BITS-1], factor_x};
        fy_wide = {factor_y[FACTOR_BITS-1], factor_y};
        fx_neg  = -fx_wide;
        fy_neg  = -fy_wide;
        fx_abs  = fx_wide[AF-1] ? fx_neg : fx_wide;
        fy_abs  = fy_wide[AF-1] ? fy_neg : fy_wide;

        rot_xc_next = dx * cosine;
        rot_ys_next = dy * sine;
        rot_xs_next = dx * sine;
        rot_yc_next = dy * cosine;
        scl_x_next  = mag_x * fx_abs;
        scl_y_next  = mag_y * fy_abs;
        trn_x_next  = {a_x_reg[CB-1], a_x_reg} + {offset_x[CB-1], offset_x};
        trn_y_next  = {a_y_reg[CB-1], a_y_reg} + {offset_y[CB-1], offset_y};

        ctrl_next.valid   = a_valid_reg;
        ctrl_next.mode    = mode;
        ctrl_next.x_above = a_x_reg > pivot_x;
        ctrl_next.x_below = a_x_reg < pivot_x;
        ctrl_next.y_above = a_y_reg > pivot_y;
        ctrl_next.y_below = a_y_reg < pivot_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            ctrl_reg    <= '0;
        end else begin
            if (in_room) begin
                a_valid_reg <= in_load;
            end
            if (b_room) begin
                ctrl_reg <= ctrl_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            a_x_reg <= in_x;
            a_y_reg <= in_y;
        end
        if (b_room && a_valid_reg) begin
            rot_xc_reg <= rot_xc_next;
            rot_ys_reg <= rot_ys_next;
            rot_xs_reg <= rot_xs_next;
            rot_yc_reg <= rot_yc_next;
            scl_x_reg  <= scl_x_next;
            scl_y_reg  <= scl_y_next;
            trn_x_reg  <= trn_x_next;
            trn_y_reg  <= trn_y_next;
            pass_x_reg <= a_x_reg;
            pass_y_reg <= a_y_reg;
        end
    end

    assign prod_ctrl = ctrl_reg;
    assign rot_xc    = rot_xc_reg;
    assign rot_ys    = rot_ys_reg;
    assign rot_xs    = rot_xs_reg;
    assign rot_yc    = rot_yc_reg;
    assign scl_x     = scl_x_reg;
    assign scl_y     = scl_y_reg;
    assign trn_x     = trn_x_reg;
    assign trn_y     = trn_y_reg;
    assign pass_x    = pass_x_reg;
    assign pass_y    = pass_y_reg;

endmodule

// ===== hw/rtl/ptx_out_stage.sv =====
// Result stage: rounds, selects by mode, saturates and holds the result.
// Fed by ptx_mul_stage; uses ptx_pkg for the mode and stage control types.
module ptx_out_stage #(
    parameter int COORD_BITS     = 24,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  ptx_pkg::ptx_stage_ctrl_t                    prod_ctrl,
    input  logic signed [COORD_BITS+TRIG_FRAC_BITS+2:0] rot_xc,
    input  logic signed [COORD_BITS+TRIG_FRAC_BITS+2:0] rot_ys,
    input  logic signed [COORD_BITS+TRIG_FRAC_BITS+2:0] rot_xs,
    input  logic signed [COORD_BITS+TRIG_FRAC_BITS+2:0] rot_yc,
    input  logic [COORD_BITS+ptx_pkg::FACTOR_BITS:0]    scl_x,
    input  logic [COORD_BITS+ptx_pkg::FACTOR_BITS:0]    scl_y,
    input  logic signed [COORD_BITS:0]                  trn_x,
    input  logic signed [COORD_BITS:0]                  trn_y,
    input  logic signed [COORD_BITS-1:0]                pass_x,
    input  logic signed [COORD_BITS-1:0]                pass_y,
    input  logic signed [COORD_BITS-1:0]                pivot_x,
    input  logic signed [COORD_BITS-1:0]                pivot_y,
    output logic                                        out_room,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [COORD_BITS-1:0]                m_out_x,
    output logic signed [COORD_BITS-1:0]                m_out_y,
    output logic                                        m_clipped
);
    import ptx_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PW = COORD_BITS + TRIG_FRAC_BITS + 3;
    localparam int SW = COORD_BITS + FACTOR_BITS + 1;
    localparam int MW = SW - 7;
    localparam int WW = COORD_BITS + 12;
    localparam logic signed [PW:0] ROT_HALF =
        {{(PW+1-TRIG_FRAC_BITS){1'b0}}, 1'b1, {(TRIG_FRAC_BITS-1){1'b0}}};
    localparam logic [SW:0] SCL_HALF = (SW+1)'(128);
    localparam logic signed [WW-1:0] HI_W = {{(WW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [WW-1:0] LO_W = ~HI_W;

    logic m_valid_reg;
    logic signed [CB-1:0] m_x_reg, m_y_reg;
    logic m_clip_reg;

    logic signed [PW:0] rsum_x, rsum_y, rshift_x, rshift_y;
    logic signed [WW-1:0] rot_x, rot_y, res_x, res_y;
    logic [CB:0] sat_x, sat_y;

    function automatic logic signed [WW-1:0] sext_coord(input logic signed [CB-1:0] v);
        return {{(WW-CB){v[CB-1]}}, v};
    endfunction

    function automatic logic signed [WW-1:0] scale_axis(input logic signed [CB-1:0] p,
                                                        input logic [SW-1:0] prod,
                                                        input logic above,
                                                        input logic below);
        logic [SW:0] rounded;
        logic signed [WW-1:0] m;
        logic signed [WW-1:0] r;
        rounded = {1'b0, prod} + SCL_HALF;
        m = {{(WW-MW){1'b0}}, rounded[SW:8]};
        if (above) begin
            r = sext_coord(p) + m;
        end else if (below) begin
            r = sext_coord(p) - m;
        end else begin
            r = sext_coord(p);
        end
        return r;
    endfunction

    function automatic logic [CB:0] sat_coord(input logic signed [WW-1:0] v);
        logic [CB:0] r;
        if (v > HI_W) begin
            r = {1'b1, HI_W[CB-1:0]};
        end else if (v < LO_W) begin
            r = {1'b1, LO_W[CB-1:0]};
        end else begin
            r = {1'b0, v[CB-1:0]};
        end
        return r;
    endfunction

    assign out_room = !m_valid_reg || m_ready;

    always_comb begin
        rsum_x   = {rot_xc[PW-1], rot_xc} - {rot_ys[PW-1], rot_ys} + ROT_HALF;
        rsum_y   = {rot_xs[PW-1], rot_xs} + {rot_yc[PW-1], rot_yc} + ROT_HALF;
        rshift_x = rsum_x >>> TRIG_FRAC_BITS;
        rshift_y = rsum_y >>> TRIG_FRAC_BITS;
        rot_x    = rshift_x[WW-1:0] + sext_coord(pivot_x);
        rot_y    = rshift_y[WW-1:0] + sext_coord(pivot_y);
        case (prod_ctrl.mode)
            MODE_ROTATE: begin
                res_x = rot_x;
                res_y = rot_y;
            end
            MODE_TRANSLATE: begin
                res_x = {{(WW-CB-1){trn_x[CB]}}, trn_x};
                res_y = {{(WW-CB-1){trn_y[CB]}}, trn_y};
            end
            MODE_SCALE: begin
                res_x = scale_axis(pivot_x, scl_x, prod_ctrl.x_above, prod_ctrl.x_below);
                res_y = scale_axis(pivot_y, scl_y, prod_ctrl.y_above, prod_ctrl.y_below);
            end
            default: begin
                res_x = sext_coord(pass_x);
                res_y = sext_coord(pass_y);
            end
        endcase
        sat_x = sat_coord(res_x);
        sat_y = sat_coord(res_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_room) begin
            m_valid_reg <= prod_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_room && prod_ctrl.valid) begin
            m_x_reg    <= sat_x[CB-1:0];
            m_y_reg    <= sat_y[CB-1:0];
            m_clip_reg <= sat_x[CB] | sat_y[CB];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_x   = m_x_reg;
    assign m_out_y   = m_y_reg;
    assign m_clipped = m_clip_reg;

endmodule

// ===== bench/point_transform_2d_core_checker.sv =====
`timescale 1ns / 100ps
// Result checker for point_transform_2d_core: follows the configuration port,
// predicts each transformed point at its input transfer and compares results in order.
// Depends on ptx_pkg for register indexes, modes and angle constants.
module point_transform_2d_core_checker #(
    parameter int COORD_BITS     = 24,
    parameter int TRIG_FRAC_BITS = 15,
    parameter int CFG_BITS       = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ptx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]                cfg_wdata,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [COORD_BITS-1:0]       s_in_x,
    input  logic signed [COORD_BITS-1:0]       s_in_y,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [COORD_BITS-1:0]       m_out_x,
    input  logic signed [COORD_BITS-1:0]       m_out_y,
    input  logic                               m_clipped,
    output int                                 fail_count,
    output int                                 in_flight
);
    import ptx_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         clipped;
    } point_t;

    localparam int     ROT_STEPS = 18;
    localparam int     ROT_FRAC  = 30;
    localparam longint ROT_GAIN  = 652032874;
    localparam int     TRIG_DROP = ROT_FRAC - TRIG_FRAC_BITS;
    localparam longint TRIG_ONE  = longint'(1) <<< TRIG_FRAC_BITS;
    localparam longint COORD_HI  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO  = -COORD_HI - 1;

    ptx_mode_t mode;
    longint    pivot_x, pivot_y, offset_x, offset_y, factor_x, factor_y, angle;
    longint    sine_q, cosine_q;
    point_t    expected_points[$];
    int        mismatches = 0;

    // Arctangent of 2^-i in degrees, scaled by 2^16.
    function automatic longint atan_step(input int i);
        case (i)
            0:       return 2949120;
            1:       return 1740968;
            2:       return 919880;
            3:       return 466945;
            4:       return 234378;
            5:       return 117303;
            6:       return 58666;
            7:       return 29335;
            8:       return 14668;
            9:       return 7334;
            10:      return 3667;
            11:      return 1833;
            12:      return 917;
            13:      return 458;
            14:      return 229;
            15:      return 115;
            16:      return 57;
            17:      return 29;
            default: return 0;
        endcase
    endfunction

    function automatic longint trig_round(input longint v);
        longint r;
        r = (v + (longint'(1) <<< (TRIG_DROP - 1))) >>> TRIG_DROP;
        if (r > TRIG_ONE) r = TRIG_ONE;
        if (r < -TRIG_ONE) r = -TRIG_ONE;
        return r;
    endfunction

    // The angle is reduced into [-180, 180) and folded into [-90, 90]; a fold
    // flips the sign of both sine and cosine.
    function automatic void refresh_trig();
        longint a, cx, cy, z, t;
        bit     flip;
        flip = 1'b0;
        a = angle % ANG_FULL;
        if (a < 0) a += ANG_FULL;
        if (a >= ANG_HALF) a -= ANG_FULL;
        if (a > ANG_QUARTER) begin
            a -= ANG_HALF;
            flip = 1'b1;
        end else if (a < -ANG_QUARTER) begin
            a += ANG_HALF;
            flip = 1'b1;
        end
        z = a * 4096;
        cx = ROT_GAIN;
        cy = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (z >= 0) begin
                t = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z -= atan_step(i);
            end else begin
                t = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z += atan_step(i);
            end
            cx = t;
        end
        cosine_q = trig_round(cx);
        sine_q = trig_round(cy);
        if (flip) begin
            cosine_q = -cosine_q;
            sine_q = -sine_q;
        end
    endfunction

    function automatic longint clamp_coord(input longint v, inout bit hit);
        if (v > COORD_HI) begin
            hit = 1'b1;
            return COORD_HI;
        end
        if (v < COORD_LO) begin
            hit = 1'b1;
            return COORD_LO;
        end
        return v;
    endfunction

    function automatic longint scale_axis(input longint v, input longint p, input longint f);
        longint mag, span, m;
        mag = (f < 0) ? -f : f;
        span = (p > v) ? p - v : v - p;
        m = (span * mag + 128) >>> 8;
        if (v > p) return p + m;
        if (v < p) return p - m;
        return p;
    endfunction

    function automatic point_t transform(input logic signed [COORD_BITS-1:0] px,
                                         input logic signed [COORD_BITS-1:0] py);
        longint x, y, rx, ry, dx, dy, half;
        bit     hit;
        point_t r;
        x = px;
        y = py;
        rx = x;
        ry = y;
        hit = 1'b0;
        half = longint'(1) <<< (TRIG_FRAC_BITS - 1);
        case (mode)
            MODE_ROTATE: begin
                dx = x - pivot_x;
                dy = y - pivot_y;
                rx = clamp_coord(((dx * cosine_q - dy * sine_q + half) >>> TRIG_FRAC_BITS)
                                 + pivot_x, hit);
                ry = clamp_coord(((dx * sine_q + dy * cosine_q + half) >>> TRIG_FRAC_BITS)
                                 + pivot_y, hit);
            end
            MODE_TRANSLATE: begin
                rx = clamp_coord(x + offset_x, hit);
                ry = clamp_coord(y + offset_y, hit);
            end
            MODE_SCALE: begin
                rx = clamp_coord(scale_axis(x, pivot_x, factor_x), hit);
                ry = clamp_coord(scale_axis(y, pivot_y, factor_y), hit);
            end
            default: ;
        endcase
        r.x = rx[COORD_BITS-1:0];
        r.y = ry[COORD_BITS-1:0];
        r.clipped = hit;
        return r;
    endfunction

    function automatic void apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [CFG_BITS-1:0] data);
        case (idx)
            REG_MODE:     mode = ptx_mode_t'(data[MODE_BITS-1:0]);
            REG_PIVOT_X:  pivot_x = longint'($signed(data[COORD_BITS-1:0]));
            REG_PIVOT_Y:  pivot_y = longint'($signed(data[COORD_BITS-1:0]));
            REG_ANGLE: begin
                angle = longint'($signed(data[ANGLE_BITS-1:0]));
                refresh_trig();
            end
            REG_OFFSET_X: offset_x = longint'($signed(data[COORD_BITS-1:0]));
            REG_OFFSET_Y: offset_y = longint'($signed(data[COORD_BITS-1:0]));
            REG_FACTOR_X: factor_x = longint'($signed(data[FACTOR_BITS-1:0]));
            REG_FACTOR_Y: factor_y = longint'($signed(data[FACTOR_BITS-1:0]));
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        point_t want, got;
        if (!aresetn) begin
            mode = MODE_ROTATE;
            pivot_x = 0;
            pivot_y = 0;
            offset_x = 0;
            offset_y = 0;
            factor_x = 256;
            factor_y = 256;
            angle = 0;
            sine_q = 0;
            cosine_q = TRIG_ONE;
            expected_points.delete();
        end else begin
            if (cfg_wr_en) apply_write(cfg_index, cfg_wdata);
            if (m_valid && m_ready) begin
                got.x = m_out_x;
                got.y = m_out_y;
                got.clipped = m_clipped;
                if (expected_points.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result transfer x=%0d y=%0d clipped=%0b",
                                 $time, got.x, got.y, got.clipped);
                    mismatches++;
                end else begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.clipped !== want.clipped)
                    begin
                        if (mismatches < 10) begin
                            $write("%0t: result mismatch: expected x=%0d y=%0d clipped=%0b,",
                                   $time, want.x, want.y, want.clipped);
                            $display(" got x=%0d y=%0d clipped=%0b",
                                     got.x, got.y, got.clipped);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_points.insert(expected_points.size(), transform(s_in_x, s_in_y));
        end
        in_flight <= expected_points.size();
        fail_count <= mismatches;
    end

endmodule

// ===== bench/point_transform_2d_core_test.sv =====
`timescale 1ns / 100ps
// Testbench top for point_transform_2d_core: clock, reset, configuration writes,
// point stimulus and result backpressure; the checker decides pass or fail.
// Needs ptx_pkg, the block's RTL and point_transform_2d_core_checker.
module point_transform_2d_core_test;
    import ptx_pkg::*;

    localparam int COORD_BITS = 24;
    localparam int CFG_BITS   = 24;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        PH_SLOW_SINK,
        PH_SLOW_SOURCE,
        PH_FULL_RATE
    } phase_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [CFG_BITS-1:0]           cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic signed [COORD_BITS-1:0]  s_in_x    = '0;
    logic signed [COORD_BITS-1:0]  s_in_y    = '0;
    logic                          m_ready   = 1'b0;
    logic                          s_ready;
    logic                          m_valid;
    logic signed [COORD_BITS-1:0]  m_out_x;
    logic signed [COORD_BITS-1:0]  m_out_y;
    logic                          m_clipped;
    int                            fail_count;
    int                            in_flight;
    phase_t                        phase = PH_SLOW_SINK;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    point_transform_2d_core #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (15)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_x    (s_in_x),
        .s_in_y    (s_in_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_x   (m_out_x),
        .m_out_y   (m_out_y),
        .m_clipped (m_clipped)
    );

    point_transform_2d_core_checker #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (15),
        .CFG_BITS       (CFG_BITS)
    ) i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_x     (s_in_x),
        .s_in_y     (s_in_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_clipped  (m_clipped),
        .fail_count (fail_count),
        .in_flight  (in_flight)
    );

    initial begin
        #2_000_000;
        $display("point_transform_2d_core regression: fail");
        $finish;
    end

    function automatic logic [COORD_BITS-1:0] random_coord();
        case ($urandom_range(0, 3))
            0: return COORD_BITS'($urandom);
            1: return COORD_BITS'($urandom_range(0, 65535) - 32768);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return COORD_BITS'($urandom_range(0, 2097151) - 1048576);
        endcase
    endfunction

    function automatic longint random_factor();
        case ($urandom_range(0, 2))
            0:       return longint'($urandom);
            1:       return longint'($urandom_range(0, 1024)) - 512;
            default: return $urandom_range(0, 1) ? longint'(256) : longint'(-256);
        endcase
    endfunction

    task automatic send_point(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
        int idle_pct;
        idle_pct = (phase == PH_SLOW_SINK) ? 36 : (phase == PH_SLOW_SOURCE) ? 59 : 0;
        s_valid <= 1'b1;
        s_in_x <= px;
        s_in_y <= py;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // An angle write keeps s_ready low while sine and cosine are formed.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input longint value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_BITS-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic random_block(input int count);
        longint mode_val, angle_val;
        settle();
        if ($urandom_range(0, 9) == 0) mode_val = longint'(MODE_PASS);
        else mode_val = longint'($urandom_range(MODE_ROTATE, MODE_SCALE));
        case ($urandom_range(0, 2))
            0:       angle_val = longint'($urandom);
            1:       angle_val = longint'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL;
            default: angle_val = (longint'($urandom_range(0, 8)) - 4) * ANG_QUARTER;
        endcase
        write_reg(REG_MODE, mode_val);
        write_reg(REG_PIVOT_X, longint'(random_coord()));
        write_reg(REG_PIVOT_Y, longint'(random_coord()));
        write_reg(REG_OFFSET_X, longint'(random_coord()));
        write_reg(REG_OFFSET_Y, longint'(random_coord()));
        write_reg(REG_FACTOR_X, random_factor());
        write_reg(REG_FACTOR_Y, random_factor());
        write_reg(REG_ANGLE, angle_val);
        repeat (count) send_point(random_coord(), random_coord());
    endtask

    // The long hold starts while points are offered, so the block fills and stalls its input.
    initial begin : sink
        bit held = 1'b0;
        forever begin
            @(posedge aclk);
            if (phase == PH_FULL_RATE && s_valid && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >=
                            ((phase == PH_SLOW_SINK) ? 59 : (phase == PH_SLOW_SOURCE) ? 36 : 0));
            end
        end
    end

    initial begin : stimulus
        longint turns [5];
        turns = '{ANG_HALF, -8192, 8191, ANG_FULL, -ANG_QUARTER - 1};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: rotation by zero about the origin.
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN);
        send_point(0, 0);
        send_point(256, -256);

        settle();
        write_reg(REG_PIVOT_X, 1000);
        write_reg(REG_PIVOT_Y, -1000);
        write_reg(REG_ANGLE, ANG_QUARTER);
        send_point(COORD_MAX, COORD_MIN);
        send_point(COORD_MIN, COORD_MAX);

        // Folded, full-turn and out-of-range angles.
        foreach (turns[i]) begin
            settle();
            write_reg(REG_ANGLE, turns[i]);
            send_point(random_coord(), random_coord());
        end

        settle();
        write_reg(REG_MODE, MODE_TRANSLATE);
        write_reg(REG_OFFSET_X, COORD_MAX);
        write_reg(REG_OFFSET_Y, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN);
        send_point(COORD_MIN, COORD_MAX);

        // Scaling with the most negative and a zero factor, points on and off the pivot.
        settle();
        write_reg(REG_MODE, MODE_SCALE);
        write_reg(REG_PIVOT_X, 256);
        write_reg(REG_PIVOT_Y, -256);
        write_reg(REG_FACTOR_X, -32768);
        write_reg(REG_FACTOR_Y, 0);
        send_point(256, 1280);
        send_point(524288, -524288);
        send_point(-512, -256);

        settle();
        write_reg(REG_MODE, MODE_PASS);
        send_point(COORD_MAX, COORD_MIN);
        send_point(123, -456);

        repeat (5) random_block(39);
        phase <= PH_SLOW_SOURCE;
        repeat (5) random_block(39);
        phase <= PH_FULL_RATE;
        repeat (5) random_block(39);

        s_valid <= 1'b0;
        @(posedge aclk);
        for (int n = 0; n < 5000 && in_flight != 0; n++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && in_flight == 0) begin
            $display("point_transform_2d_core regression: pass");
        end else begin
            $display("point_transform_2d_core regression: fail");
        end
        $finish;
    end

endmodule
